[sv/gyro_bias_tracker_core_defines.svh]
// Assertion macros shared by the gyro bias tracker checkers
`ifndef GYRO_BIAS_TRACKER_CORE_DEFINES_SVH
`define GYRO_BIAS_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbt: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define GBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbt: assertion failed");

`endif

[sv/gbt_pkg.sv]
// Shared constants, types and control struct for the gyro bias tracker
package gbt_pkg;

  // Averaging window and datapath widths
  localparam int unsigned WINDOW = 1000;
  localparam int unsigned LANES  = 3;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned SUM_W  = 27;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  // Exact reciprocal of WINDOW for dividends below 2**SUM_W
  localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam logic [63:0] RECIP_WIDE  =
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic [LANES-1:0][SMP_W-1:0] lane_vec_t;

  // Control broadcast from the sequencer to every lane
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic moving;  // transferred sample is a moving one
    logic full;    // window already full before this sample
    logic upd;     // item in second stage refreshes the offset
    logic adv;     // second stage moves on this cycle
  } lane_ctl_t;

endpackage

[sv/gyro_bias_tracker_core.sv]
// Top level: window sequencer, three axis lanes and the merge stage
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid_i / in_stall_o  | sample_x/y/z_i, moving_i
//   out     | source    | out_valid_o / out_stall_i | comp_x/y/z_o
//
// One sample per cycle while in_stall_o is low; a result passes through the
// stage-two and output registers. The bound is the per-lane divide by the
// window (one constant reciprocal multiply) that feeds the next sum update.
// Reset clears the count, sums, offsets and calibrated flag at once.
// in_stall_o rises only while both stages hold work and out_stall_i is high.
module gyro_bias_tracker_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   sample_x_i,
  input  logic signed [15:0]   sample_y_i,
  input  logic signed [15:0]   sample_z_i,
  input  logic                 moving_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   comp_x_o,
  output logic signed [15:0]   comp_y_o,
  output logic signed [15:0]   comp_z_o
);

  logic [gbt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      cal_q, cal_d;
  logic                      v_q, v_d;
  logic                      upd_q, upd_d;
  logic                      emit_q;
  logic                      accept, adv, out_free, full, upd_now;
  gbt_pkg::lane_ctl_t        ctl;
  gbt_pkg::lane_vec_t        smp_vec, lane_comp, comp_vec;

  // Handshake: stage two moves when the output register is free
  assign adv        = v_q & out_free;
  assign in_stall_o = v_q & ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;

  // Window sequencer
  assign full    = (cnt_q >= gbt_pkg::CNT_FULL);
  assign upd_now = ~moving_i & (full | (cnt_q == gbt_pkg::CNT_LAST));

  always_comb begin
    cnt_d = cnt_q;
    cal_d = cal_q;
    if (accept) begin
      if (moving_i) begin
        cnt_d = '0;
      end else if (!full) begin
        cnt_d = cnt_q + 1'b1;
      end
      cal_d = cal_q | upd_now;
    end
  end

  // Stage-two occupancy and offset refresh marker
  always_comb begin
    v_d   = v_q;
    upd_d = upd_q;
    if (accept) begin
      v_d   = 1'b1;
      upd_d = upd_now;
    end else if (adv) begin
      v_d   = 1'b0;
      upd_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cal_q  <= 1'b0;
      v_q    <= 1'b0;
      upd_q  <= 1'b0;
      emit_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cal_q <= cal_d;
      v_q   <= v_d;
      upd_q <= upd_d;
      if (accept) begin
        emit_q <= cal_q | upd_now;
      end
    end
  end

  assign ctl.accept = accept;
  assign ctl.moving = moving_i;
  assign ctl.full   = full;
  assign ctl.upd    = upd_q;
  assign ctl.adv    = adv;

  assign smp_vec[0] = sample_x_i;
  assign smp_vec[1] = sample_y_i;
  assign smp_vec[2] = sample_z_i;

  // Axis lanes
  for (genvar g = 0; g < gbt_pkg::LANES; g++) begin : g_lane
    gbt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .smp_i  (smp_vec[g]),
      .comp_o (lane_comp[g])
    );
  end

  gbt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .emit_i      (emit_q),
    .lane_comp_i (lane_comp),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_free_o  (out_free),
    .comp_o      (comp_vec)
  );

  assign comp_x_o = comp_vec[0];
  assign comp_y_o = comp_vec[1];
  assign comp_z_o = comp_vec[2];

endmodule

[sv/gbt_lane.sv]
// One axis lane: running sum, offset estimate and compensation
module gbt_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbt_pkg::lane_ctl_t ctl_i,
  input  gbt_pkg::smp_t     smp_i,
  output gbt_pkg::smp_t     comp_o
);

  localparam int unsigned PROD_W = gbt_pkg::SUM_W + gbt_pkg::RECIP_W;

  logic signed [gbt_pkg::SUM_W-1:0] sum_q, sum_d;
  gbt_pkg::smp_t                    off_q, off_eff, smp_q;

  logic [gbt_pkg::SUM_W-1:0]        mag;
  logic [PROD_W-1:0]                prod;
  logic [PROD_W-1:0]                quo_wide;
  logic signed [gbt_pkg::SUM_W:0]   quo_s;
  gbt_pkg::smp_t                    quo_sat;
  logic signed [gbt_pkg::SMP_W:0]   diff;

  // Truncating divide of the current sum by the window
  always_comb begin
    mag      = sum_q[gbt_pkg::SUM_W-1] ? gbt_pkg::SUM_W'(-sum_q) : gbt_pkg::SUM_W'(sum_q);
    prod     = PROD_W'(mag) * PROD_W'(gbt_pkg::RECIP);
    quo_wide = prod >> gbt_pkg::RECIP_SHIFT;
    quo_s    = $signed({1'b0, quo_wide[gbt_pkg::SUM_W-1:0]});
    if (sum_q[gbt_pkg::SUM_W-1]) begin
      quo_s = -quo_s;
    end
    if (quo_s > (gbt_pkg::SUM_W+1)'(32767)) begin
      quo_sat = 16'sh7FFF;
    end else if (quo_s < -(gbt_pkg::SUM_W+1)'(32768)) begin
      quo_sat = 16'sh8000;
    end else begin
      quo_sat = quo_s[gbt_pkg::SMP_W-1:0];
    end
  end

  // Forward a fresh offset while the refreshing item sits in stage two
  assign off_eff = ctl_i.upd ? quo_sat : off_q;

  // Sum update: cleared on motion, accumulates until full, then leaky; wraps at SUM_W bits
  always_comb begin
    sum_d = sum_q;
    if (ctl_i.accept) begin
      if (ctl_i.moving) begin
        sum_d = '0;
      end else if (ctl_i.full) begin
        sum_d = sum_q - gbt_pkg::SUM_W'(off_eff) + gbt_pkg::SUM_W'(smp_i);
      end else begin
        sum_d = sum_q + gbt_pkg::SUM_W'(smp_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      off_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (ctl_i.adv) begin
        off_q <= off_eff;
      end
    end
  end

  // Stage-two sample register
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      smp_q <= smp_i;
    end
  end

  // Compensated rate, saturated to 16 bits
  always_comb begin
    diff = (gbt_pkg::SMP_W+1)'(smp_q) - (gbt_pkg::SMP_W+1)'(off_eff);
    if (diff > (gbt_pkg::SMP_W+1)'(32767)) begin
      comp_o = 16'sh7FFF;
    end else if (diff < -(gbt_pkg::SMP_W+1)'(32768)) begin
      comp_o = 16'sh8000;
    end else begin
      comp_o = diff[gbt_pkg::SMP_W-1:0];
    end
  end

endmodule

[sv/gbt_merge.sv]
// Merge stage: gathers the lane results into the output register
module gbt_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               emit_i,
  input  gbt_pkg::lane_vec_t lane_comp_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               out_free_o,
  output gbt_pkg::lane_vec_t comp_o
);

  logic               out_valid_q, out_valid_d;
  gbt_pkg::lane_vec_t comp_q;

  // Register can take a new result when empty or being drained
  assign out_free_o = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_i) begin
      out_valid_d = emit_i;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload only loads on a stage-two move
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      comp_q <= lane_comp_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign comp_o      = comp_q;

endmodule

[sv/gbt_checker.sv]
// Port-level checker for the gyro bias tracker, bound to the top level
`include "gyro_bias_tracker_core_defines.svh"

module gbt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [15:0] sample_x_i,
  input logic signed [15:0] sample_y_i,
  input logic signed [15:0] sample_z_i,
  input logic               moving_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] comp_x_o,
  input logic signed [15:0] comp_y_o,
  input logic signed [15:0] comp_z_o
);

  logic        in_wait, out_wait;
  logic [48:0] in_all;
  logic [47:0] comp_all;

  // Waiting transfers and their payloads
  assign in_wait  = in_valid_i && in_stall_o;
  assign out_wait = out_valid_o && out_stall_i;
  assign in_all   = {moving_i, sample_x_i, sample_y_i, sample_z_i};
  assign comp_all = {comp_x_o, comp_y_o, comp_z_o};

  // Input only back-pressures when a result is held by a stalled sink
  `GBT_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_wait)

  // A stalled sample holds its transfer
  `GBT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_all))

  // A stalled result holds its transfer
  `GBT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(comp_all))

  // No result on the first edge out of reset
  `GBT_ASSERT_NOW(a_reset_quiet, clk_i, rst_ni, !$past(rst_ni), !out_valid_o)

endmodule

bind gyro_bias_tracker_core gbt_checker u_gbt_checker (.*);

[dv/tb_gyro_bias_tracker_core.sv]
// Self-checking testbench for the gyro bias tracker core
`timescale 1ns / 100ps

module tb_gyro_bias_tracker_core;

  localparam int RANDOM_ITEMS = 60;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic          moving;
    gbt_pkg::smp_t x;
    gbt_pkg::smp_t y;
    gbt_pkg::smp_t z;
  } gyro_sample_t;

  typedef struct packed {
    gbt_pkg::smp_t x;
    gbt_pkg::smp_t y;
    gbt_pkg::smp_t z;
  } rate_comp_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          out_stall_i = 1'b0;
  logic          moving_i    = 1'b0;
  gbt_pkg::smp_t sample_x_i  = '0;
  gbt_pkg::smp_t sample_y_i  = '0;
  gbt_pkg::smp_t sample_z_i  = '0;
  logic          in_stall_o;
  logic          out_valid_o;
  gbt_pkg::smp_t comp_x_o;
  gbt_pkg::smp_t comp_y_o;
  gbt_pkg::smp_t comp_z_o;

  gyro_sample_t samples_to_send [$];
  rate_comp_t   comp_due [$];
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // Predictor state: rest counter, running sums, offsets and calibrated flag
  bit                               is_calibrated = 1'b0;
  int unsigned                      at_rest_count = 0;
  logic signed [gbt_pkg::SUM_W-1:0] rest_sum [3] = '{default: '0};
  gbt_pkg::smp_t                    zero_rate [3] = '{default: '0};

  // Idle and stall draws, with bursts of back-to-back traffic
  int  send_gap = 0;
  int  stall_left = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  gyro_bias_tracker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sample_z_i (sample_z_i),
    .moving_i   (moving_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .comp_x_o   (comp_x_o),
    .comp_y_o   (comp_y_o),
    .comp_z_o   (comp_z_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic gbt_pkg::smp_t clamp16(longint v);
    if (v > 32767) return gbt_pkg::smp_t'(16'sd32767);
    if (v < -32768) return gbt_pkg::smp_t'(-32768);
    return gbt_pkg::smp_t'(v);
  endfunction

  function automatic gbt_pkg::smp_t near(int centre, int spread);
    return clamp16(longint'(centre) + longint'($urandom_range(0, 2 * spread))
                   - longint'(spread));
  endfunction

  function automatic int any_bias();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Offset tracking and compensation for one accepted sample
  task automatic track_bias(gyro_sample_t s);
    longint     rate [3];
    longint     acc;
    bit         was_full;
    rate_comp_t c;
    rate[0] = longint'($signed(s.x));
    rate[1] = longint'($signed(s.y));
    rate[2] = longint'($signed(s.z));
    if (s.moving) begin
      at_rest_count = 0;
      for (int i = 0; i < 3; i++) rest_sum[i] = '0;
    end else begin
      was_full = (at_rest_count >= gbt_pkg::WINDOW);
      if (!was_full) at_rest_count = at_rest_count + 1;
      for (int i = 0; i < 3; i++) begin
        acc = longint'(rest_sum[i]);
        // leaky update once the window is full
        if (was_full) acc -= longint'(zero_rate[i]);
        acc += rate[i];
        rest_sum[i] = acc[gbt_pkg::SUM_W-1:0];
      end
      if (at_rest_count == gbt_pkg::WINDOW) begin
        for (int i = 0; i < 3; i++)
          zero_rate[i] = clamp16(longint'(rest_sum[i]) / longint'(gbt_pkg::WINDOW));
        is_calibrated = 1'b1;
      end
    end
    if (is_calibrated) begin
      c.x = clamp16(rate[0] - longint'(zero_rate[0]));
      c.y = clamp16(rate[1] - longint'(zero_rate[1]));
      c.z = clamp16(rate[2] - longint'(zero_rate[2]));
      comp_due.push_back(c);
    end
  endtask

  task automatic push_sample(int x, int y, int z, logic mv);
    gyro_sample_t s;
    s.moving = mv;
    s.x = gbt_pkg::smp_t'(x);
    s.y = gbt_pkg::smp_t'(y);
    s.z = gbt_pkg::smp_t'(z);
    samples_to_send.push_back(s);
  endtask

  task automatic push_rest_run(int count, int bx, int by, int bz, int spread);
    for (int k = 0; k < count; k++)
      push_sample(near(bx, spread), near(by, spread), near(bz, spread), 1'b0);
  endtask

  task automatic push_noise(int count);
    for (int k = 0; k < count; k++)
      push_sample(int'($urandom), int'($urandom), int'($urandom), 1'($urandom));
  endtask

  // Input driver: one transfer per item, random gap before each
  always @(posedge clk_i or negedge rst_ni) begin
    gyro_sample_t s;
    bit           held;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      moving_i   <= 1'b0;
      sample_x_i <= '0;
      sample_y_i <= '0;
      sample_z_i <= '0;
    end else begin
      held = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        s.moving = moving_i;
        s.x = sample_x_i;
        s.y = sample_y_i;
        s.z = sample_z_i;
        track_bias(s);
        held = 1'b0;
        if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : int'($urandom_range(0, 9));
      end
      if (!held) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          s = samples_to_send.pop_front();
          moving_i   <= s.moving;
          sample_x_i <= s.x;
          sample_y_i <= s.y;
          sample_z_i <= s.z;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    rate_comp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (comp_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d %0d %0d",
                                    comp_x_o, comp_y_o, comp_z_o));
        end else begin
          want = comp_due.pop_front();
          if (comp_x_o !== want.x)
            report_mismatch($sformatf("comp_x got %0d want %0d", comp_x_o, $signed(want.x)));
          if (comp_y_o !== want.y)
            report_mismatch($sformatf("comp_y got %0d want %0d", comp_y_o, $signed(want.y)));
          if (comp_z_o !== want.z)
            report_mismatch($sformatf("comp_z got %0d want %0d", comp_z_o, $signed(want.z)));
        end
        if ($urandom_range(0, 63) == 0) recv_burst = ~recv_burst;
        stall_left = recv_burst ? 0 : int'($urandom_range(0, 9));
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_gyro_bias_tracker_core failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int fed;
    int pick;
    int run_len;
    int vals [5];
    vals = '{32767, -32768, 0, -1, 1};

    // Uncalibrated: extremes and moving flags, no results expected
    push_sample(32767, -32768, 0, 1'b0);
    push_sample(-32768, 32767, -1, 1'b0);
    push_sample(0, 0, 0, 1'b1);
    push_sample(-1, 1, 32767, 1'b1);
    push_sample('h5555, 'hAAAA, 'h5555, 1'b0);
    push_sample('hAAAA, 'h5555, 'hAAAA, 1'b0);
    push_sample(-32768, -32768, -32768, 1'b1);

    // Partial window, then a moving sample clears the count
    push_rest_run(20, any_bias(), any_bias(), any_bias(), 3000);
    push_sample(int'($urandom), int'($urandom), int'($urandom), 1'b1);

    // Full window at extreme offsets, then into the leaky phase
    for (int k = 0; k < gbt_pkg::WINDOW + 30; k++)
      push_sample(32767, -32768, near(-200, 40), 1'b0);

    // Calibrated: saturation both ways, moving sample still compensated
    push_sample(-32768, 32767, 0, 1'b0);
    push_sample(-32768, 32767, 32767, 1'b1);
    push_sample(32767, -32768, -32768, 1'b0);
    push_sample(0, 0, 0, 1'b0);
    push_sample(-1, -1, -1, 1'b1);

    // Random part: short rest runs ended by motion, some noise and extremes
    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run_len = $urandom_range(1, 20);
        push_rest_run(run_len, any_bias(), any_bias(), any_bias(),
                      int'($urandom_range(0, 300)));
        push_sample(int'($urandom), int'($urandom), int'($urandom), 1'b1);
        fed += run_len + 1;
      end else if (pick < 95) begin
        run_len = $urandom_range(1, 10);
        push_noise(run_len);
        fed += run_len;
      end else begin
        for (int k = 0; k < 4; k++)
          push_sample(vals[$urandom_range(0, 4)], vals[$urandom_range(0, 4)],
                      vals[$urandom_range(0, 4)], 1'($urandom));
        fed += 4;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all items sent, all results seen, then a short settling wait
    while (samples_to_send.size() != 0 || in_valid_i) @(negedge clk_i);
    while (comp_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb_gyro_bias_tracker_core passed");
    end else begin
      $display("tb_gyro_bias_tracker_core failed");
    end
    $finish;
  end

endmodule
